@@ sv/sorted_alarm_timer_queue_top_macros.svh @@
// Assertion helpers for the sorted alarm timer queue checker.
`ifndef SORTED_ALARM_TIMER_QUEUE_TOP_MACROS_SVH
`define SORTED_ALARM_TIMER_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define SATQ_ASSERT_SAME(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("satq check failed");

// Next-cycle implication, off while reset is held.
`define SATQ_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("satq check failed");

// Next-cycle implication that also runs during reset.
`define SATQ_ASSERT_NEXT_ALWAYS(lbl, clk, a, c) \
    lbl: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("satq check failed");

`endif

@@ sv/satq_pkg.sv @@
// ----------------------------------------------------------------------------
// satq_pkg
// Shared types and constants of the sorted alarm timer queue.
// ----------------------------------------------------------------------------
package satq_pkg;

    localparam int MAX_RESULTS = 16;
    localparam int NDUE_W      = 5;
    localparam int FIELD_W     = 16;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

@@ sv/satq_mem.sv @@
// ----------------------------------------------------------------------------
// satq_mem
// Entry RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module satq_mem #(
    parameter int DEPTH = 16,
    parameter int EW    = 64
) (
    input  logic                     i_clk,
    input  satq_pkg::t_mem_ctl       i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    input  logic [EW-1:0]            i_wdata,
    output logic [EW-1:0]            o_rdata
);

    logic [EW-1:0] r_ram [DEPTH];
    logic [EW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_ram[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_ram[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/satq_ctrl.sv @@
// ----------------------------------------------------------------------------
// satq_ctrl
// Sequencer: insertion shift from the tail, due-alarm pops from the head.
// ----------------------------------------------------------------------------
module satq_ctrl #(
    parameter int DEPTH = 16,
    parameter int TW    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,
    output logic                          o_m_tuser,
    output logic                          o_m_tlast,
    output satq_pkg::t_mem_ctl            o_mem_ctl,
    output logic [$clog2(DEPTH)-1:0]      o_waddr,
    output logic [$clog2(DEPTH)-1:0]      o_raddr,
    output logic [TW+31:0]                o_wdata,
    input  logic [TW+31:0]                i_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = TW + 32;

    typedef enum logic [2:0] {
        S_IDLE, S_A_RD, S_A_CHK, S_T_RD, S_T_CHK, S_T_LAST
    } t_state;

    t_state                     r_state;
    logic [TW-1:0]              r_time;
    logic [CW-1:0]              r_count;
    logic [AW-1:0]              r_head;
    logic [CW-1:0]              r_pos;
    logic [EW-1:0]              r_new;
    logic [satq_pkg::NDUE_W-1:0] r_ndue;
    logic                       r_pend;
    logic [31:0]                r_pend_data;
    logic                       r_ov;
    logic [31:0]                r_odata;
    logic                       r_okind;
    logic                       r_olast;

    logic          w_free;
    logic          w_le;
    logic          w_due;
    logic          w_load;
    logic [TW:0]   n_sum;
    logic [TW-1:0] n_deadline;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, off};
        if (sum >= (CW + 1)'(DEPTH)) begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign w_free     = !r_ov || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_free;
    assign w_le       = i_rdata[EW-1:32] <= r_new[EW-1:32];
    assign w_due      = i_rdata[EW-1:32] <= r_time;

    // load the output register: reject, non-final pop, final pop
    assign w_load = ((r_state == S_IDLE) && i_s_tvalid && o_s_tready &&
                     (i_s_tuser == satq_pkg::CMD_ADD) && (r_count == CW'(DEPTH))) ||
                    ((r_state == S_T_CHK) && w_due && r_pend && w_free) ||
                    ((r_state == S_T_LAST) && w_free);

    always_comb begin
        n_sum      = {1'b0, r_time} + (TW + 1)'(i_s_tdata[15:0]);
        n_deadline = n_sum[TW] ? '1 : n_sum[TW-1:0];
    end

    always_comb begin
        o_mem_ctl = '0;
        o_waddr   = f_phys(r_head, r_pos);
        o_raddr   = r_head;
        o_wdata   = r_new;
        case (r_state)
            S_A_RD: begin
                if (r_pos == '0) begin
                    o_mem_ctl.we = 1'b1;
                end else begin
                    o_mem_ctl.re = 1'b1;
                    o_raddr      = f_phys(r_head, r_pos - CW'(1));
                end
            end
            S_A_CHK: begin
                o_mem_ctl.we = 1'b1;
                o_wdata      = w_le ? r_new : i_rdata;
            end
            S_T_RD: begin
                o_mem_ctl.re = (r_count != '0) &&
                               (r_ndue != satq_pkg::NDUE_W'(satq_pkg::MAX_RESULTS));
            end
            default: begin
                o_mem_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_time  <= '0;
            r_count <= '0;
            r_head  <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid && o_s_tready) begin
                        if (i_s_tuser == satq_pkg::CMD_ADD) begin
                            if (r_count == CW'(DEPTH)) begin
                                r_okind <= satq_pkg::KIND_REJECT;
                                r_odata <= i_s_tdata;
                                r_olast <= 1'b1;
                            end else begin
                                r_new   <= {n_deadline, i_s_tdata[15:0], i_s_tdata[31:16]};
                                r_pos   <= r_count;
                                r_state <= S_A_RD;
                            end
                        end else begin
                            if (r_time != '1) begin
                                r_time <= r_time + TW'(1);
                            end
                            r_ndue  <= '0;
                            r_state <= S_T_RD;
                        end
                    end
                end
                S_A_RD: begin
                    if (r_pos == '0) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_A_CHK;
                    end
                end
                S_A_CHK: begin
                    if (w_le) begin
                        r_count <= r_count + CW'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_pos   <= r_pos - CW'(1);
                        r_state <= S_A_RD;
                    end
                end
                S_T_RD: begin
                    if (r_count == '0 ||
                        r_ndue == satq_pkg::NDUE_W'(satq_pkg::MAX_RESULTS)) begin
                        r_state <= r_pend ? S_T_LAST : S_IDLE;
                    end else begin
                        r_state <= S_T_CHK;
                    end
                end
                S_T_CHK: begin
                    if (w_due) begin
                        if (!r_pend || w_free) begin
                            if (r_pend) begin
                                r_okind <= satq_pkg::KIND_FIRED;
                                r_odata <= r_pend_data;
                                r_olast <= 1'b0;
                            end
                            // the delay sits above the handle in an entry
                            r_pend_data <= {i_rdata[15:0], i_rdata[31:16]};
                            r_pend      <= 1'b1;
                            r_head      <= f_phys(r_head, CW'(1));
                            r_count     <= r_count - CW'(1);
                            r_ndue      <= r_ndue + satq_pkg::NDUE_W'(1);
                            r_state     <= S_T_RD;
                        end
                    end else begin
                        r_state <= r_pend ? S_T_LAST : S_IDLE;
                    end
                end
                S_T_LAST: begin
                    if (w_free) begin
                        r_okind <= satq_pkg::KIND_FIRED;
                        r_odata <= r_pend_data;
                        r_olast <= 1'b1;
                        r_pend  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_okind;
    assign o_m_tlast  = r_olast;

endmodule

@@ sv/sorted_alarm_timer_queue_top.sv @@
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue_top
// Deadline-sorted alarm queue held in a circular entry RAM.
//
// Channel  Dir  Beat fields
// s side   in   tuser: cmd; tdata: delay_seconds[15:0], message_handle[31:16]
// m side   out  tuser: kind; tdata: fired_seconds[15:0], fired_handle[31:16];
//               tlast: last
//
// An add shifts every stored alarm with a later deadline one place toward
// the tail and stops at the first stored alarm that is not later; each step
// is one read and one write of the entry RAM. A tick pops the due alarms
// from the head and stops at the first remaining alarm that is not due.
// Reset clears the time, the count and the head pointer; the RAM holds no
// reset state. A stalled m side holds the sequencer at its next result.
// ----------------------------------------------------------------------------
module sorted_alarm_timer_queue_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_WIDTH  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // delay_seconds[15:0], message_handle[31:16]
    input  logic        i_s_tuser,   // cmd[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // fired_seconds[15:0], fired_handle[31:16]
    output logic        o_m_tuser,   // kind[0]
    output logic        o_m_tlast
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int EW = TIME_WIDTH + 32;

    satq_pkg::t_mem_ctl w_mem_ctl;
    logic [AW-1:0]      w_waddr;
    logic [AW-1:0]      w_raddr;
    logic [EW-1:0]      w_wdata;
    logic [EW-1:0]      w_rdata;

    // sequence inserts and pops against the entry RAM
    satq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .TW    (TIME_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .o_mem_ctl  (w_mem_ctl),
        .o_waddr    (w_waddr),
        .o_raddr    (w_raddr),
        .o_wdata    (w_wdata),
        .i_rdata    (w_rdata)
    );

    // entries: deadline, delay, handle from the top bits down
    satq_mem #(
        .DEPTH (QUEUE_DEPTH),
        .EW    (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_raddr (w_raddr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

endmodule

@@ sv/satq_checker.sv @@
// ----------------------------------------------------------------------------
// satq_checker
// Port-level checks of the sorted alarm timer queue.
// ----------------------------------------------------------------------------
`include "sorted_alarm_timer_queue_top_macros.svh"

module satq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    `SATQ_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_m_tvalid)
    `SATQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))
    `SATQ_ASSERT_SAME(a_reject_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == satq_pkg::KIND_REJECT, o_m_tlast)

endmodule

bind sorted_alarm_timer_queue_top satq_checker u_satq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
